// ===== design/bmhq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared widths, operation and error codes, and the result beat type of the
// binary max-heap queue.
// ----------------------------------------------------------------------------
package bmhq_pkg;

  localparam int KEY_W   = 32;
  localparam int TAG_W   = 16;
  localparam int COUNT_W = 10;
  localparam int ERR_W   = 2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_FULL  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [TAG_W-1:0]   tag;
    logic [COUNT_W-1:0] count;
    logic               empty;
    logic [ERR_W-1:0]   err;
  } result_t;

endpackage

// ===== design/binary_max_heap_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_max_heap_queue
// Max-heap priority queue on unsigned Q16.16 keys with a tag per entry.
// ----------------------------------------------------------------------------
// One operation at a time: an insert lets the new entry climb toward the root,
// and a removal moves the last entry to the root and lets it sink, or empties
// the heap. Each level costs one read of the single read port of the entry
// memory (on the way down the left child, then the right one if it exists) plus
// the compare. Busy falls in the cycle of the done strobe; the result beat
// stands for that one cycle only, since the receiver cannot stall.
// ----------------------------------------------------------------------------
module binary_max_heap_queue
  import bmhq_pkg::*;
#(
  parameter int CAPACITY  = 1023,
  parameter int TAG_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               op,
  input  logic [KEY_W-1:0]   entry_key,
  input  logic [TAG_W-1:0]   entry_tag,
  output logic               done,
  output logic [KEY_W-1:0]   top_key,
  output logic [TAG_W-1:0]   top_tag,
  output logic [COUNT_W-1:0] entry_count,
  output logic               is_empty,
  output logic [ERR_W-1:0]   op_error
);

  localparam int SW = (TAG_WIDTH < TAG_W) ? TAG_WIDTH : TAG_W;
  localparam int IW = $clog2(CAPACITY + 1);

  logic                mem_we;
  logic [IW-1:0]       mem_waddr;
  logic [KEY_W+SW-1:0] mem_wdata;
  logic [IW-1:0]       mem_raddr;
  logic [KEY_W+SW-1:0] mem_rdata;
  logic                res_valid;
  result_t             res;

  bmhq_ctrl #(
    .CAPACITY (CAPACITY),
    .SW       (SW),
    .IW       (IW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .op        (op),
    .entry_key (entry_key),
    .entry_tag (entry_tag),
    .busy      (busy),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res       (res)
  );

  bmhq_ram #(
    .DEPTH (CAPACITY + 1),
    .AW    (IW),
    .DW    (KEY_W + SW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // result beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      top_key     <= res.key;
      top_tag     <= res.tag;
      entry_count <= res.count;
      is_empty    <= res.empty;
      op_error    <= res.err;
    end
  end

endmodule

// ===== design/bmhq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmhq_ram
// Entry memory: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bmhq_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 48
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== design/bmhq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmhq_ctrl
// Sift sequencer: carries the moving entry in registers, walks the heap one
// level at a time through the entry memory and keeps the root and count.
// ----------------------------------------------------------------------------
module bmhq_ctrl
  import bmhq_pkg::*;
#(
  parameter int CAPACITY = 1023,
  parameter int SW       = 16,
  parameter int IW       = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               op,
  input  logic [KEY_W-1:0]   entry_key,
  input  logic [TAG_W-1:0]   entry_tag,
  output logic               busy,
  output logic               mem_we,
  output logic [IW-1:0]      mem_waddr,
  output logic [KEY_W+SW-1:0] mem_wdata,
  output logic [IW-1:0]      mem_raddr,
  input  logic [KEY_W+SW-1:0] mem_rdata,
  output logic               res_valid,
  output result_t            res
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_UP     = 3'd1;
  localparam logic [2:0] ST_UPCMP  = 3'd2;
  localparam logic [2:0] ST_RDLAST = 3'd3;
  localparam logic [2:0] ST_DN     = 3'd4;
  localparam logic [2:0] ST_DNL    = 3'd5;
  localparam logic [2:0] ST_DNR    = 3'd6;
  localparam logic [2:0] ST_DONE   = 3'd7;

  localparam logic [IW-1:0] ROOT = IW'(1);
  localparam logic [IW-1:0] FULL = IW'(CAPACITY);

  logic [2:0]       state;
  logic [IW-1:0]    count;
  logic [IW-1:0]    slot;
  logic [IW-1:0]    child;
  logic [KEY_W-1:0] cur_key;
  logic [SW-1:0]    cur_tag;
  logic [KEY_W-1:0] l_key;
  logic [SW-1:0]    l_tag;
  logic [KEY_W-1:0] root_key;
  logic [SW-1:0]    root_tag;
  logic [ERR_W-1:0] err;

  logic [KEY_W-1:0] rd_key;
  logic [SW-1:0]    rd_tag;
  logic [IW:0]      left_idx;
  logic             no_child;
  logic             right_ok;
  logic             sel_right;
  logic [KEY_W-1:0] cand_key;
  logic [SW-1:0]    cand_tag;
  logic [IW-1:0]    cand_idx;
  logic             up_swap;
  logic             dn_swap;

  assign rd_key    = mem_rdata[KEY_W+SW-1:SW];
  assign rd_tag    = mem_rdata[SW-1:0];
  assign left_idx  = {slot, 1'b0};
  assign no_child  = left_idx > {1'b0, count};
  assign right_ok  = {slot, 1'b1} <= {1'b0, count};
  assign sel_right = (state == ST_DNR) && (rd_key > l_key);
  assign cand_key  = (state == ST_DNL || sel_right) ? rd_key : l_key;
  assign cand_tag  = (state == ST_DNL || sel_right) ? rd_tag : l_tag;
  assign cand_idx  = sel_right ? child + ROOT : child;
  assign up_swap   = rd_key < cur_key;
  assign dn_swap   = cand_key > cur_key;
  assign busy      = state != ST_IDLE;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = slot;
    mem_wdata = {cur_key, cur_tag};
    mem_raddr = slot;
    case (state)
      ST_IDLE: begin
        mem_raddr = count;
      end
      ST_UP: begin
        if (slot == ROOT) begin
          mem_we = 1'b1;
        end else begin
          mem_raddr = slot >> 1;
        end
      end
      ST_UPCMP: begin
        mem_we = 1'b1;
        if (up_swap) begin
          mem_wdata = mem_rdata;
        end
      end
      ST_DN: begin
        if (no_child) begin
          mem_we = 1'b1;
        end else begin
          mem_raddr = left_idx[IW-1:0];
        end
      end
      ST_DNL: begin
        if (right_ok) begin
          mem_raddr = child + ROOT;
        end else begin
          mem_we = 1'b1;
          if (dn_swap) begin
            mem_wdata = {cand_key, cand_tag};
          end
        end
      end
      ST_DNR: begin
        mem_we = 1'b1;
        if (dn_swap) begin
          mem_wdata = {cand_key, cand_tag};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      err   <= ERR_OK;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            err <= ERR_OK;
            if (op == OP_INSERT) begin
              if (count >= FULL) begin
                err   <= ERR_FULL;
                state <= ST_DONE;
              end else begin
                count <= count + ROOT;
                state <= ST_UP;
              end
            end else begin
              if (count == '0) begin
                err   <= ERR_EMPTY;
                state <= ST_DONE;
              end else begin
                count <= count - ROOT;
                state <= ST_RDLAST;
              end
            end
          end
        end
        ST_UP: begin
          state <= (slot == ROOT) ? ST_DONE : ST_UPCMP;
        end
        ST_UPCMP: begin
          state <= up_swap ? ST_UP : ST_DONE;
        end
        ST_RDLAST: begin
          state <= (count == '0) ? ST_DONE : ST_DN;
        end
        ST_DN: begin
          state <= no_child ? ST_DONE : ST_DNL;
        end
        ST_DNL: begin
          if (right_ok) begin
            state <= ST_DNR;
          end else begin
            state <= dn_swap ? ST_DN : ST_DONE;
          end
        end
        ST_DNR: begin
          state <= dn_swap ? ST_DN : ST_DONE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cur_key <= entry_key;
        cur_tag <= SW'(entry_tag);
        slot    <= count + ROOT;
      end
      ST_UPCMP: begin
        if (up_swap) begin
          slot <= slot >> 1;
        end
      end
      ST_RDLAST: begin
        cur_key <= rd_key;
        cur_tag <= rd_tag;
        slot    <= ROOT;
      end
      ST_DN: begin
        child <= left_idx[IW-1:0];
      end
      ST_DNL: begin
        l_key <= rd_key;
        l_tag <= rd_tag;
        if (!right_ok && dn_swap) begin
          slot <= cand_idx;
        end
      end
      ST_DNR: begin
        if (dn_swap) begin
          slot <= cand_idx;
        end
      end
      default: begin
      end
    endcase
    if (mem_we && mem_waddr == ROOT) begin
      root_key <= mem_wdata[KEY_W+SW-1:SW];
      root_tag <= mem_wdata[SW-1:0];
    end
  end

  assign res_valid = state == ST_DONE;
  assign res.key   = (count != '0) ? root_key : '0;
  assign res.tag   = (count != '0) ? TAG_W'(root_tag) : '0;
  assign res.count = COUNT_W'(count);
  assign res.empty = count == '0;
  assign res.err   = err;

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= FULL)
    else $error("entry count above capacity");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted beat did not start the sequencer");

  a_write_states: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == ST_UP || state == ST_UPCMP || state == ST_DN ||
                state == ST_DNL || state == ST_DNR))
    else $error("entry write outside a sift step");

  a_err_count: assert property (@(posedge clk) disable iff (rst)
    res_valid && err != ERR_OK |-> count == $past(count))
    else $error("rejected operation changed the count");

endmodule

// ===== tb/binary_max_heap_queue_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_max_heap_queue_test
// Self-checking bench for the max-heap priority queue. A queue of pending
// commands (directed corner cases, then random phases that fill the heap to
// capacity and then mostly remove) feeds a clocked driver. Each accepted command
// runs through a shadow heap that predicts the top entry, the count and the
// error code, and a clocked monitor compares every done beat with the oldest
// prediction. Sender gaps vary by phase; a watchdog ends a hung run.
// ----------------------------------------------------------------------------
module binary_max_heap_queue_test;
  import bmhq_pkg::*;

  localparam int CAPACITY    = 1023;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_WAIT  = 60;

  typedef struct {
    logic             op;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
    int               idle_pct;
  } heap_cmd_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic               op = OP_INSERT;
  logic [KEY_W-1:0]   entry_key = '0;
  logic [TAG_W-1:0]   entry_tag = '0;
  logic               done;
  logic [KEY_W-1:0]   top_key;
  logic [TAG_W-1:0]   top_tag;
  logic [COUNT_W-1:0] entry_count;
  logic               is_empty;
  logic [ERR_W-1:0]   op_error;

  heap_cmd_t pending_cmds[$];
  result_t   top_expect[$];

  logic [KEY_W-1:0] shadow_key [1:CAPACITY];
  logic [TAG_W-1:0] shadow_tag [1:CAPACITY];
  int               shadow_fill = 0;
  int               gen_fill = 0;
  int               errors = 0;
  int               stall_cycles = 0;

  binary_max_heap_queue #(
    .CAPACITY (CAPACITY),
    .TAG_WIDTH(TAG_W)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .op         (op),
    .entry_key  (entry_key),
    .entry_tag  (entry_tag),
    .done       (done),
    .top_key    (top_key),
    .top_tag    (top_tag),
    .entry_count(entry_count),
    .is_empty   (is_empty),
    .op_error   (op_error)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic void swap_shadow(int a, int b);
    logic [KEY_W-1:0] k;
    logic [TAG_W-1:0] t;
    k = shadow_key[a];
    t = shadow_tag[a];
    shadow_key[a] = shadow_key[b];
    shadow_tag[a] = shadow_tag[b];
    shadow_key[b] = k;
    shadow_tag[b] = t;
  endfunction

  function automatic result_t apply_heap_op(logic cmd_op, logic [KEY_W-1:0] key,
                                            logic [TAG_W-1:0] tag);
    result_t r;
    int      s;
    int      c;
    bit      moving;
    r.err = ERR_OK;
    if (cmd_op == OP_INSERT) begin
      if (shadow_fill >= CAPACITY) begin
        r.err = ERR_FULL;
      end else begin
        shadow_fill++;
        s = shadow_fill;
        shadow_key[s] = key;
        shadow_tag[s] = tag;
        moving = 1'b1;
        while (moving && s > 1) begin
          if (shadow_key[s / 2] < shadow_key[s]) begin
            swap_shadow(s / 2, s);
            s = s / 2;
          end else begin
            moving = 1'b0;
          end
        end
      end
    end else begin
      if (shadow_fill == 0) begin
        r.err = ERR_EMPTY;
      end else begin
        shadow_key[1] = shadow_key[shadow_fill];
        shadow_tag[1] = shadow_tag[shadow_fill];
        shadow_fill--;
        s = 1;
        moving = 1'b1;
        while (moving && 2 * s <= shadow_fill) begin
          c = 2 * s;
          if (c + 1 <= shadow_fill && shadow_key[c + 1] > shadow_key[c]) c = c + 1;
          if (shadow_key[c] > shadow_key[s]) begin
            swap_shadow(c, s);
            s = c;
          end else begin
            moving = 1'b0;
          end
        end
      end
    end
    r.key   = (shadow_fill > 0) ? shadow_key[1] : '0;
    r.tag   = (shadow_fill > 0) ? shadow_tag[1] : '0;
    r.count = COUNT_W'(shadow_fill);
    r.empty = (shadow_fill == 0);
    return r;
  endfunction

  task automatic push_cmd(logic cmd_op, logic [KEY_W-1:0] key, logic [TAG_W-1:0] tag,
                          int idle_pct);
    heap_cmd_t c;
    c.op = cmd_op;
    c.key = key;
    c.tag = tag;
    c.idle_pct = idle_pct;
    pending_cmds.push_back(c);
    if (cmd_op == OP_INSERT && gen_fill < CAPACITY) gen_fill++;
    if (cmd_op == OP_REMOVE && gen_fill > 0) gen_fill--;
  endtask

  // mix of full-range, clustered (many ties) and extreme keys
  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 4))
      0: return KEY_W'($urandom_range(0, 7));
      1: return {16'hFFFF, 16'($urandom_range(0, 3))};
      2: return {16'($urandom_range(0, 15)), 16'h0000};
      default: return $urandom;
    endcase
  endfunction

  task automatic push_random(int n, int insert_pct, int idle_pct);
    for (int i = 0; i < n; i++) begin
      push_cmd(($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE,
               pick_key(), 16'($urandom), idle_pct);
    end
  endtask

  // driver
  always @(posedge clk) begin : drive
    heap_cmd_t nxt;
    bit        taken;
    taken = 1'b0;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        top_expect.push_back(apply_heap_op(op, entry_key, entry_tag));
        taken = 1'b1;
      end
      if (!start || taken) begin
        if (pending_cmds.size() > 0 &&
            $urandom_range(0, 99) >= pending_cmds[0].idle_pct) begin
          nxt = pending_cmds.pop_front();
          start     <= 1'b1;
          op        <= nxt.op;
          entry_key <= nxt.key;
          entry_tag <= nxt.tag;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [31:0] expv, logic [31:0] actv);
    if (expv !== actv) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, expv, actv);
      errors++;
    end
  endtask

  // monitor and watchdog count
  always @(posedge clk) begin : watch
    result_t want;
    if (rst || (start && !busy) || done) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (!rst && done) begin
      if (top_expect.size() == 0) begin
        $display("%0t: unexpected beat, expected none actual key %h tag %h count %0d",
                 $time, top_key, top_tag, entry_count);
        errors++;
      end else begin
        want = top_expect.pop_front();
        check_field("top_key", want.key, top_key);
        check_field("top_tag", want.tag, top_tag);
        check_field("entry_count", want.count, entry_count);
        check_field("is_empty", want.empty, is_empty);
        check_field("op_error", want.err, op_error);
      end
    end
  end

  initial begin
    while (rst || stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("binary_max_heap_queue verification failed");
    $finish;
  end

  initial begin
    // directed corners
    push_cmd(OP_REMOVE, 32'hFFFF_FFFF, 16'hFFFF, 0);
    push_cmd(OP_INSERT, 32'h0000_0000, 16'h0000, 0);
    push_cmd(OP_REMOVE, 32'h0000_0000, 16'h0000, 0);
    push_cmd(OP_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 0);
    push_cmd(OP_INSERT, 32'h0001_0000, 16'h1234, 0);
    push_cmd(OP_INSERT, 32'h0001_0000, 16'h4321, 0);
    push_cmd(OP_INSERT, 32'hFFFF_FFFF, 16'hAAAA, 0);
    push_cmd(OP_INSERT, 32'h0001_0000, 16'h5555, 0);
    push_cmd(OP_INSERT, 32'h8000_0000, 16'h5A5A, 0);
    for (int i = 0; i < 6; i++) push_cmd(OP_REMOVE, 32'h0, 16'h0, 0);
    push_cmd(OP_REMOVE, 32'h0, 16'hFFFF, 0);
    for (int i = 1; i <= 5; i++) push_cmd(OP_INSERT, 32'd7, 16'(i), 0);
    for (int i = 0; i < 4; i++) push_cmd(OP_REMOVE, 32'h0, 16'h0, 0);
    // random phases
    push_random(150, 55, 0);
    while (gen_fill < CAPACITY) push_random(1, 95, 45);
    push_cmd(OP_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 45);
    push_cmd(OP_INSERT, 32'h0000_0000, 16'h0000, 45);
    push_cmd(OP_INSERT, $urandom, 16'($urandom), 45);
    push_cmd(OP_REMOVE, $urandom, 16'($urandom), 45);
    push_cmd(OP_INSERT, pick_key(), 16'($urandom), 45);
    push_cmd(OP_INSERT, pick_key(), 16'($urandom), 45);
    push_random(200, 30, 13);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (pending_cmds.size() != 0 || start || top_expect.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("binary_max_heap_queue verification clean");
    end else begin
      $display("binary_max_heap_queue verification failed");
    end
    $finish;
  end

endmodule
